[sv/mpz_pkg.sv]
// Shared types, fixed-point constants and saturation helper for the Mandelbrot renderer.
`default_nettype none

package mpz_pkg;

  // Q7.24 fixed point
  localparam int FRAC_BITS = 24;
  localparam int WIDE_W    = 66;
  localparam int SPAN_W    = 28;
  localparam int SPLIT     = 14;
  localparam int MAP_STAGES = 7;

  localparam logic signed [31:0] Q_MAX = 32'sd1073741824;
  localparam logic signed [31:0] Q_MIN = -32'sd1073741824;
  localparam logic signed [32:0] ESCAPE_LIM = 33'sd67108864;

  localparam logic [SPAN_W-1:0] SPAN_MIN = 28'd1;
  localparam logic [SPAN_W-1:0] SPAN_MAX = 28'd134217728;

  localparam logic [15:0] PAN_K      = 16'd33554;
  localparam logic [24:0] ZOOM_IN_K  = 25'd16743646;
  localparam logic [24:0] ZOOM_OUT_K = 25'd16810787;

  localparam logic signed [31:0] RST_RE_ORG  = -32'sd35232154;
  localparam logic [SPAN_W-1:0]  RST_RE_SPAN = 28'd6291456;
  localparam logic signed [31:0] RST_IM_ORG  = -32'sd2013266;
  localparam logic [SPAN_W-1:0]  RST_IM_SPAN = 28'd4194304;

  // button states of a frame-end transaction
  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
    logic zin;
    logic zout;
  } ctl_t;

  // control travelling with a pixel through the iteration stages
  typedef struct packed {
    logic vld;
    logic done;
  } itc_t;

  // clamp to [-64.0, +64.0]
  function automatic logic signed [31:0] sat_q(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(Q_MAX);
    lo = WIDE_W'(Q_MIN);
    if (v > hi) begin
      sat_q = Q_MAX;
    end else if (v < lo) begin
      sat_q = Q_MIN;
    end else begin
      sat_q = v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

[sv/mpz_window.sv]
// View window registers with pan and zoom update on frame-end transactions.
`default_nettype none

module mpz_window
  import mpz_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     upd,
  input  wire ctl_t                     ctl,
  output logic signed [31:0]            re_org,
  output logic        [SPAN_W-1:0]      re_span,
  output logic signed [31:0]            im_org,
  output logic        [SPAN_W-1:0]      im_span
);

  logic [SPAN_W+15:0] re_pp, im_pp;
  logic [SPAN_W-9:0]  re_step, im_step;
  logic [24:0]        zk;
  logic [SPAN_W+24:0] re_zp, im_zp;
  logic [SPAN_W:0]    re_zq, im_zq;
  logic signed [WIDE_W-1:0] re_sstep, im_sstep;
  logic signed [31:0] re_org_next, im_org_next;
  logic [SPAN_W-1:0]  re_span_next, im_span_next;

  // pan steps from the span before zoom
  always_comb begin
    re_pp    = (SPAN_W+16)'(re_span) * (SPAN_W+16)'(PAN_K);
    im_pp    = (SPAN_W+16)'(im_span) * (SPAN_W+16)'(PAN_K);
    re_step  = re_pp[SPAN_W+15:FRAC_BITS];
    im_step  = im_pp[SPAN_W+15:FRAC_BITS];
    re_sstep = $signed(WIDE_W'(re_step));
    im_sstep = $signed(WIDE_W'(im_step));
  end

  // origin update: horizontal wins over vertical
  always_comb begin
    re_org_next = re_org;
    im_org_next = im_org;
    if (ctl.left || ctl.right) begin
      re_org_next = sat_q(WIDE_W'(re_org) + (ctl.right ? -re_sstep : re_sstep));
    end else if (ctl.up || ctl.down) begin
      im_org_next = sat_q(WIDE_W'(im_org) + (ctl.down ? -im_sstep : im_sstep));
    end
  end

  // zoom with clamp to [1 LSB, 8.0]
  always_comb begin
    zk    = ctl.zin ? ZOOM_IN_K : ZOOM_OUT_K;
    re_zp = (SPAN_W+25)'(re_span) * (SPAN_W+25)'(zk);
    im_zp = (SPAN_W+25)'(im_span) * (SPAN_W+25)'(zk);
    re_zq = re_zp[SPAN_W+24:FRAC_BITS];
    im_zq = im_zp[SPAN_W+24:FRAC_BITS];
    re_span_next = re_span;
    im_span_next = im_span;
    if (ctl.zin || ctl.zout) begin
      if (re_zq < (SPAN_W+1)'(SPAN_MIN)) begin
        re_span_next = SPAN_MIN;
      end else if (re_zq > (SPAN_W+1)'(SPAN_MAX)) begin
        re_span_next = SPAN_MAX;
      end else begin
        re_span_next = re_zq[SPAN_W-1:0];
      end
      if (im_zq < (SPAN_W+1)'(SPAN_MIN)) begin
        im_span_next = SPAN_MIN;
      end else if (im_zq > (SPAN_W+1)'(SPAN_MAX)) begin
        im_span_next = SPAN_MAX;
      end else begin
        im_span_next = im_zq[SPAN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      re_org  <= RST_RE_ORG;
      re_span <= RST_RE_SPAN;
      im_org  <= RST_IM_ORG;
      im_span <= RST_IM_SPAN;
    end else if (upd) begin
      re_org  <= re_org_next;
      re_span <= re_span_next;
      im_org  <= im_org_next;
      im_span <= im_span_next;
    end
  end

endmodule

`default_nettype wire

[sv/mpz_mapper.sv]
// Seven-stage screen-to-plane mapping: origin + floor(pix * span / DIVISOR), saturated.
`default_nettype none

module mpz_mapper
  import mpz_pkg::*;
#(
  parameter int PIX_W   = 10,
  parameter int DIVISOR = 640
)(
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [PIX_W-1:0]        px,
  input  wire logic signed [31:0]      origin,
  input  wire logic [SPAN_W-1:0]       span,
  output logic signed [31:0]           c
);

  localparam int DIV_W = $clog2(DIVISOR);
  localparam int HI_W  = SPAN_W - SPLIT;
  localparam int NH_W  = PIX_W + HI_W;
  localparam int NL_W  = PIX_W + SPLIT;
  localparam int N2_W  = ((DIV_W > PIX_W) ? DIV_W : PIX_W) + SPLIT + 1;
  localparam int SH    = NH_W + DIV_W;
  localparam int SL    = N2_W + DIV_W;
  localparam int MH_W  = NH_W + 1;
  localparam int ML_W  = N2_W + 1;
  localparam int PH_W  = SH + NH_W;
  localparam int PL_W  = SL + N2_W;
  localparam int OFF_W = PIX_W + SPAN_W + 1;
  localparam logic [63:0] M_HI64 = (64'd1 << SH) / DIVISOR;
  localparam logic [63:0] M_LO64 = (64'd1 << SL) / DIVISOR;
  localparam logic [MH_W-1:0] M_HI = M_HI64[MH_W-1:0];
  localparam logic [ML_W-1:0] M_LO = M_LO64[ML_W-1:0];
  localparam logic [DIV_W:0]  DIV_C = (DIV_W+1)'(DIVISOR);

  // stage registers
  logic [NH_W-1:0]  p_hi1, p_hi2;
  logic [NL_W-1:0]  p_lo1, p_lo2, p_lo3;
  logic [NH_W-1:0]  q_hi2, q_hi3, q_hi4, q_hi5, q_hi6;
  logic [DIV_W:0]   r_hi3, r_lo6;
  logic [N2_W-1:0]  n2_4, n2_5;
  logic [N2_W-1:0]  q_lo5, q_lo6;
  logic signed [31:0] org1, org2, org3, org4, org5, org6;

  logic [PH_W-1:0]  ph;
  logic [PL_W-1:0]  pl;
  logic             ge_hi, ge_lo;
  logic [DIV_W-1:0] rem_hi;
  logic [N2_W-1:0]  q_lo;
  logic [OFF_W-1:0] off;

  always_comb begin
    ph     = PH_W'(p_hi1) * PH_W'(M_HI);
    pl     = PL_W'(n2_4) * PL_W'(M_LO);
    ge_hi  = r_hi3 >= DIV_C;
    rem_hi = ge_hi ? DIV_W'(r_hi3 - DIV_C) : DIV_W'(r_hi3);
    ge_lo  = r_lo6 >= DIV_C;
    q_lo   = q_lo6 + N2_W'(ge_lo);
    off    = (OFF_W'(q_hi6) << SPLIT) + OFF_W'(q_lo);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // partial products on the split span
      p_hi1 <= NH_W'(px) * NH_W'(span[SPAN_W-1:SPLIT]);
      p_lo1 <= NL_W'(px) * NL_W'(span[SPLIT-1:0]);
      org1  <= origin;
      // quotient estimate of the high part
      q_hi2 <= ph[SH +: NH_W];
      p_hi2 <= p_hi1;
      p_lo2 <= p_lo1;
      org2  <= org1;
      // high remainder estimate
      r_hi3 <= (DIV_W+1)'(p_hi2 - q_hi2 * NH_W'(DIVISOR));
      q_hi3 <= q_hi2;
      p_lo3 <= p_lo2;
      org3  <= org2;
      // correct, fold remainder into the low part
      q_hi4 <= q_hi3 + NH_W'(ge_hi);
      n2_4  <= (N2_W'(rem_hi) << SPLIT) + N2_W'(p_lo3);
      org4  <= org3;
      // low quotient estimate
      q_lo5 <= pl[SL +: N2_W];
      n2_5  <= n2_4;
      q_hi5 <= q_hi4;
      org5  <= org4;
      // low remainder estimate
      r_lo6 <= (DIV_W+1)'(n2_5 - q_lo5 * N2_W'(DIVISOR));
      q_lo6 <= q_lo5;
      q_hi6 <= q_hi5;
      org6  <= org5;
      // final offset and saturation
      c     <= sat_q(WIDE_W'(org6) + $signed(WIDE_W'({1'b0, off})));
    end
  end

endmodule

`default_nettype wire

[sv/mpz_iter.sv]
// One escape-time iteration in three register stages.
`default_nettype none

module mpz_iter
  import mpz_pkg::*;
#(
  parameter int CNT_W = 4
)(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire itc_t                ctl_in,
  input  wire logic [CNT_W-1:0]    cnt_in,
  input  wire logic signed [31:0]  c_re_in,
  input  wire logic signed [31:0]  c_im_in,
  input  wire logic signed [31:0]  zr_in,
  input  wire logic signed [31:0]  zi_in,
  input  wire logic signed [31:0]  zr2_in,
  input  wire logic signed [31:0]  zi2_in,
  output itc_t                     ctl_out,
  output logic [CNT_W-1:0]         cnt_out,
  output logic signed [31:0]       c_re_out,
  output logic signed [31:0]       c_im_out,
  output logic signed [31:0]       zr_out,
  output logic signed [31:0]       zi_out,
  output logic signed [31:0]       zr2_out,
  output logic signed [31:0]       zi2_out
);

  itc_t               a_ctl, b_ctl;
  logic [CNT_W-1:0]   a_cnt, b_cnt;
  logic signed [63:0] a_prod;
  logic signed [31:0] a_zr, a_cre, a_cim;
  logic signed [31:0] b_zr, b_zi, b_zr2, b_cre, b_cim;

  logic signed [32:0] mag;
  logic               esc;
  itc_t               ctl_a_next;
  logic signed [63:0] sq_r, sq_i;

  // escape test on the incoming magnitude
  always_comb begin
    mag  = 33'(zr2_in) + 33'(zi2_in);
    esc  = mag > ESCAPE_LIM;
    ctl_a_next.vld  = ctl_in.vld;
    ctl_a_next.done = ctl_in.done | esc;
    sq_r = 64'(a_zr) * 64'(a_zr);
    sq_i = 64'(b_zi) * 64'(b_zi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl   <= '0;
      b_ctl   <= '0;
      ctl_out <= '0;
    end else if (en) begin
      a_ctl   <= ctl_a_next;
      b_ctl   <= a_ctl;
      ctl_out <= b_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage A: cross product, new real part, count
      a_cnt  <= cnt_in + CNT_W'(!ctl_a_next.done);
      a_prod <= 64'(zr_in) * 64'(zi_in);
      a_zr   <= sat_q(WIDE_W'(zr2_in) - WIDE_W'(zi2_in) + WIDE_W'(c_re_in));
      a_cre  <= c_re_in;
      a_cim  <= c_im_in;
      // stage B: new imaginary part, square of real part
      b_cnt  <= a_cnt;
      b_zr   <= a_zr;
      b_zi   <= sat_q((WIDE_W'(a_prod >>> FRAC_BITS) <<< 1) + WIDE_W'(a_cim));
      b_zr2  <= sat_q(WIDE_W'(sq_r >>> FRAC_BITS));
      b_cre  <= a_cre;
      b_cim  <= a_cim;
      // stage C: square of imaginary part
      cnt_out  <= b_cnt;
      zr_out   <= b_zr;
      zi_out   <= b_zi;
      zr2_out  <= b_zr2;
      zi2_out  <= sat_q(WIDE_W'(sq_i >>> FRAC_BITS));
      c_re_out <= b_cre;
      c_im_out <= b_cim;
    end
  end

endmodule

`default_nettype wire

[sv/mandelbrot_pixel_renderer_pan_zoom_core.sv]
// Top level: window registers, coordinate mappers, iteration pipeline, gray output.
//
//  channel  direction  handshake            payload
//  input    in         in_valid / in_ready  op, pixel_x, pixel_y, move_*, zoom_*_req
//  output   out        out_valid/out_ready  iteration_count, gray_level
//
// One transaction per cycle while the output is not stalled. A pixel result passes
// through 7 mapping stages, 3 stages per unrolled iteration and one output register.
// Frame-end transactions update the window at acceptance and make no result.
// Synchronous reset clears all valid bits and loads the default window.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none

module mandelbrot_pixel_renderer_pan_zoom_core
  import mpz_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480,
  parameter int ITER_LIMIT    = 14
)(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [9:0]  pixel_x,
  input  wire logic [8:0]  pixel_y,
  input  wire logic        move_up,
  input  wire logic        move_down,
  input  wire logic        move_left,
  input  wire logic        move_right,
  input  wire logic        zoom_in_req,
  input  wire logic        zoom_out_req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       iteration_count,
  output logic [7:0]       gray_level
);

  localparam int CNT_W = $clog2(ITER_LIMIT + 1);

  logic                 adv;
  ctl_t                 ctl;
  logic signed [31:0]   re_org, im_org;
  logic [SPAN_W-1:0]    re_span, im_span;
  logic [MAP_STAGES-1:0] vmap;
  logic signed [31:0]   c_re0, c_im0;

  itc_t               ch_ctl  [ITER_LIMIT+1];
  logic [CNT_W-1:0]   ch_cnt  [ITER_LIMIT+1];
  logic signed [31:0] ch_cre  [ITER_LIMIT+1];
  logic signed [31:0] ch_cim  [ITER_LIMIT+1];
  logic signed [31:0] ch_zr   [ITER_LIMIT+1];
  logic signed [31:0] ch_zi   [ITER_LIMIT+1];
  logic signed [31:0] ch_zr2  [ITER_LIMIT+1];
  logic signed [31:0] ch_zi2  [ITER_LIMIT+1];
  logic [7:0]         gray_tab [ITER_LIMIT+1];
  logic [7:0]         cnt8;

  // global advance: output register empty or being taken
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  assign ctl.up    = move_up;
  assign ctl.down  = move_down;
  assign ctl.left  = move_left;
  assign ctl.right = move_right;
  assign ctl.zin   = zoom_in_req;
  assign ctl.zout  = zoom_out_req;

  mpz_window u_window (
    .clk     (clk),
    .rst     (rst),
    .upd     (in_valid && in_ready && op),
    .ctl     (ctl),
    .re_org  (re_org),
    .re_span (re_span),
    .im_org  (im_org),
    .im_span (im_span)
  );

  mpz_mapper #(.PIX_W(10), .DIVISOR(SCREEN_WIDTH)) u_map_re (
    .clk    (clk),
    .en     (adv),
    .px     (pixel_x),
    .origin (re_org),
    .span   (re_span),
    .c      (c_re0)
  );

  mpz_mapper #(.PIX_W(9), .DIVISOR(SCREEN_HEIGHT)) u_map_im (
    .clk    (clk),
    .en     (adv),
    .px     (pixel_y),
    .origin (im_org),
    .span   (im_span),
    .c      (c_im0)
  );

  // valid bits alongside the mapping stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vmap <= '0;
    end else if (adv) begin
      vmap <= {vmap[MAP_STAGES-2:0], in_valid && !op};
    end
  end

  // iteration chain entry: z = 0
  assign ch_ctl[0].vld  = vmap[MAP_STAGES-1];
  assign ch_ctl[0].done = 1'b0;
  assign ch_cnt[0] = '0;
  assign ch_cre[0] = c_re0;
  assign ch_cim[0] = c_im0;
  assign ch_zr[0]  = '0;
  assign ch_zi[0]  = '0;
  assign ch_zr2[0] = '0;
  assign ch_zi2[0] = '0;

  for (genvar i = 0; i < ITER_LIMIT; i++) begin : g_iter
    mpz_iter #(.CNT_W(CNT_W)) u_iter (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .ctl_in   (ch_ctl[i]),
      .cnt_in   (ch_cnt[i]),
      .c_re_in  (ch_cre[i]),
      .c_im_in  (ch_cim[i]),
      .zr_in    (ch_zr[i]),
      .zi_in    (ch_zi[i]),
      .zr2_in   (ch_zr2[i]),
      .zi2_in   (ch_zi2[i]),
      .ctl_out  (ch_ctl[i+1]),
      .cnt_out  (ch_cnt[i+1]),
      .c_re_out (ch_cre[i+1]),
      .c_im_out (ch_cim[i+1]),
      .zr_out   (ch_zr[i+1]),
      .zi_out   (ch_zi[i+1]),
      .zr2_out  (ch_zr2[i+1]),
      .zi2_out  (ch_zi2[i+1])
    );
  end

  // gray level table, fixed at elaboration
  for (genvar g = 0; g <= ITER_LIMIT; g++) begin : g_gray
    localparam int GV = 255 - (g * 255) / ITER_LIMIT;
    assign gray_tab[g] = GV[7:0];
  end

  assign cnt8 = 8'(ch_cnt[ITER_LIMIT]);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ch_ctl[ITER_LIMIT].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      iteration_count <= cnt8[3:0];
      gray_level      <= gray_tab[ch_cnt[ITER_LIMIT]];
    end
  end

  // checks
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> $stable(vmap))
    else $error("mapping valid bits moved during a stall");

  a_frame_no_pixel: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && op) |=> !vmap[0])
    else $error("frame-end transaction entered the pixel pipeline");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ITER_LIMIT > 15 || 32'(iteration_count) <= ITER_LIMIT))
    else $error("iteration count beyond limit");

  a_zero_white: assert property (@(posedge clk) disable iff (rst)
    (out_valid && iteration_count == 4'd0 && ITER_LIMIT < 16) |-> gray_level == 8'd255)
    else $error("zero count not mapped to full level");

  a_span_range: assert property (@(posedge clk) disable iff (rst)
    re_span >= SPAN_MIN && re_span <= SPAN_MAX && im_span >= SPAN_MIN && im_span <= SPAN_MAX)
    else $error("window span out of range");

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the Mandelbrot pixel renderer with pan and zoom.
`timescale 1ns / 100ps

module tb
  import mpz_pkg::*;
();

  localparam int SCR_W = 640;
  localparam int SCR_H = 480;
  localparam int ITERS = 14;
  localparam int LATENCY = 7 + 3 * ITERS + 1;
  localparam int N_RANDOM = 1930;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  localparam longint QLIM = 64'sd1073741824;
  localparam longint ESC = 64'sd67108864;
  localparam longint SPN_MAX = 64'sd134217728;

  typedef struct packed {
    logic       op;
    logic [9:0] px;
    logic [8:0] py;
    ctl_t       ctl;
  } txn_t;

  typedef struct packed {
    logic [3:0] cnt;
    logic [7:0] gray;
  } pix_res_t;

  // directed row: transaction plus optional hand-typed result
  typedef struct packed {
    txn_t     t;
    logic     typed;
    pix_res_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = 1'b0;
  logic [9:0] pixel_x = '0;
  logic [8:0] pixel_y = '0;
  logic move_up = 1'b0, move_down = 1'b0, move_left = 1'b0, move_right = 1'b0;
  logic zoom_in_req = 1'b0, zoom_out_req = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] iteration_count;
  logic [7:0] gray_level;

  mandelbrot_pixel_renderer_pan_zoom_core #(
    .SCREEN_WIDTH(SCR_W), .SCREEN_HEIGHT(SCR_H), .ITER_LIMIT(ITERS)
  ) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .move_up(move_up), .move_down(move_down),
    .move_left(move_left), .move_right(move_right), .zoom_in_req(zoom_in_req),
    .zoom_out_req(zoom_out_req), .out_valid(out_valid), .out_ready(out_ready),
    .iteration_count(iteration_count), .gray_level(gray_level)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor window state
  longint win_re_org, win_re_spn, win_im_org, win_im_spn;
  pix_res_t pending_pixels[$];
  int errors = 0;
  int n_pixels = 0, n_frames = 0, n_results = 0;
  bit hold_off = 0;

  function automatic longint clamp_q(longint v);
    if (v > QLIM) return QLIM;
    if (v < -QLIM) return -QLIM;
    return v;
  endfunction

  // floor division by 2^24 (arithmetic shift floors)
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic pix_res_t predict_pixel(logic [9:0] px, logic [8:0] py);
    longint cre, cim, zr, zi, zr2, zi2, zr_old;
    int n;
    pix_res_t r;
    cre = clamp_q(win_re_org + (longint'(px) * win_re_spn) / SCR_W);
    cim = clamp_q(win_im_org + (longint'(py) * win_im_spn) / SCR_H);
    zr = 0; zi = 0; zr2 = 0; zi2 = 0; n = 0;
    for (int i = 0; i < ITERS; i++) begin
      if (zr2 + zi2 > ESC) break;
      zr_old = zr;
      zi = clamp_q(2 * qmul(zr_old, zi) + cim);
      zr = clamp_q(zr2 - zi2 + cre);
      zr2 = clamp_q(qmul(zr, zr));
      zi2 = clamp_q(qmul(zi, zi));
      n++;
    end
    r.cnt = 4'(n);
    r.gray = 8'(255 - (n * 255) / ITERS);
    return r;
  endfunction

  function automatic longint zoom_span(longint s, longint k);
    longint v;
    v = (s * k) >>> FRAC_BITS;
    if (v < 1) v = 1;
    if (v > SPN_MAX) v = SPN_MAX;
    return v;
  endfunction

  function automatic void apply_frame(ctl_t c);
    longint rs, is;
    rs = (win_re_spn * longint'(PAN_K)) >>> FRAC_BITS;
    is = (win_im_spn * longint'(PAN_K)) >>> FRAC_BITS;
    // horizontal pan wins; right and down carry the negative sign
    if (c.left || c.right)
      win_re_org = clamp_q(win_re_org + (c.right ? -rs : rs));
    else if (c.up || c.down)
      win_im_org = clamp_q(win_im_org + (c.down ? -is : is));
    if (c.zin || c.zout) begin
      win_re_spn = zoom_span(win_re_spn, c.zin ? ZOOM_IN_K : ZOOM_OUT_K);
      win_im_spn = zoom_span(win_im_spn, c.zin ? ZOOM_IN_K : ZOOM_OUT_K);
    end
  endfunction

  // offer one transaction after a gap, wait for acceptance; valid stays up afterwards
  task automatic send(txn_t t, int gap, bit typed, pix_res_t res);
    pix_res_t p;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= t.op;
    pixel_x <= t.px;
    pixel_y <= t.py;
    {move_up, move_down, move_left, move_right, zoom_in_req, zoom_out_req} <= t.ctl;
    do @(posedge clk); while (!in_ready);
    if (t.op == OP_PIXEL) begin
      p = predict_pixel(t.px, t.py);
      if (typed && p !== res)
        $display("%0t: table row result %h disagrees with prediction %h", $time, res, p);
      pending_pixels.push_back(typed ? res : p);
      n_pixels++;
    end else begin
      apply_frame(t.ctl);
      n_frames++;
    end
  endtask

  function automatic txn_t pix(int x, int y);
    txn_t t;
    t = '0;
    t.op = OP_PIXEL; t.px = 10'(x); t.py = 9'(y);
    return t;
  endfunction

  function automatic txn_t frm(ctl_t c);
    txn_t t;
    t = '0;
    t.op = OP_FRAME; t.ctl = c;
    return t;
  endfunction

  function automatic txn_t rnd_txn();
    txn_t t;
    int k;
    t = '0;
    k = $urandom_range(0, 99);
    if (k < 88) begin
      t = pix(k < 80 ? $urandom_range(0, 639) : $urandom_range(640, 1023),
              k < 80 ? $urandom_range(0, 479) : $urandom_range(480, 511));
      t.ctl = ctl_t'(6'($urandom));  // ignored for pixels
    end else begin
      t = frm(ctl_t'(6'($urandom)));
      t.px = 10'($urandom); t.py = 9'($urandom);
    end
    return t;
  endfunction

  // directed stimulus
  row_t dir_rows[$];
  initial begin
    dir_rows = '{
      '{pix(0, 0), 1'b1, '{4'd1, 8'd237}},    // far corner escapes after one step
      '{pix(639, 479), 1'b0, '0},
      '{pix(1023, 511), 1'b0, '0},
      '{pix(320, 240), 1'b0, '0},
      '{pix(639, 0), 1'b0, '0},
      '{pix(0, 479), 1'b0, '0},
      '{frm(6'b001100), 1'b0, '0},            // left with right: right wins
      '{frm(6'b110000), 1'b0, '0},            // up with down: down wins
      '{frm(6'b101000), 1'b0, '0},            // horizontal beats vertical
      '{frm(6'b000011), 1'b0, '0},            // zoom in beats zoom out
      '{frm(6'b000001), 1'b0, '0},
      '{frm(6'b100000), 1'b0, '0},
      '{frm(6'b000100), 1'b0, '0},
      '{frm(6'b000000), 1'b0, '0},
      '{pix(512, 256), 1'b0, '0},
      '{pix(341, 170), 1'b0, '0},
      '{frm(6'b111111), 1'b0, '0},
      '{pix(100, 400), 1'b0, '0}
    };
  end

  // output side: random stalls plus one long hold-off
  initial begin
    int st;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      st = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
      out_ready <= (st == 0);
      if (st != 0) begin
        repeat (st) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // checker
  always @(posedge clk) begin
    pix_res_t e;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result cnt=%0d gray=%0d", $time, iteration_count, gray_level);
        errors++;
      end else begin
        e = pending_pixels.pop_front();
        if (iteration_count !== e.cnt) begin
          $display("%0t: iteration_count exp %0d got %0d", $time, e.cnt, iteration_count);
          errors++;
        end
        if (gray_level !== e.gray) begin
          $display("%0t: gray_level exp %0d got %0d", $time, e.gray, gray_level);
          errors++;
        end
      end
    end
  end

  // main sequence
  initial begin
    txn_t t;
    int gap;
    win_re_org = RST_RE_ORG; win_re_spn = RST_RE_SPAN;
    win_im_org = RST_IM_ORG; win_im_spn = RST_IM_SPAN;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) send(dir_rows[i].t, 0, dir_rows[i].typed, dir_rows[i].res);
    // sender pause until drained
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    // random part, back-to-back burst during a long output hold-off
    hold_off = 1;
    for (int i = 0; i < N_RANDOM; i++) begin
      t = rnd_txn();
      gap = (i < 200 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
      send(t, gap, 0, '0);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d pixels, %0d frame-end transactions, %0d results checked.",
             n_pixels, n_frames, n_results);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
